// ===== sv/pcf_pkg.sv =====
// Shared types, constants and the CRC-32 byte fold for the PNG chunk framer.
`timescale 1ns / 1ps
package pcf_pkg;

	// Reflected CRC-32 polynomial, preset and final inversion value.
	localparam logic [31:0] CRC_POLY = 32'hedb88320;
	localparam logic [31:0] CRC_ONES = 32'hffffffff;

	// Default depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH_DEF = 4;

	// Input item kinds.
	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_DATA   = 1'b1;

	// One input item.
	typedef struct packed {
		logic        kind;
		logic [31:0] chunk_type;
		logic [30:0] payload_length;
		logic [7:0]  data_byte;
	} pcf_in_t;

	// One result item.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       chunk_done;
		logic       framing_error;
	} pcf_out_t;

	// Commands the front hands to the back.
	typedef enum logic [2:0] {
		OP_HDR,
		OP_HDR_EMPTY,
		OP_DATA,
		OP_DATA_LAST,
		OP_ERR
	} pcf_op_t;

	// One queue entry: the word holds the chunk type or the data byte, and len
	// carries the payload length of a header.
	typedef struct packed {
		pcf_op_t     op;
		logic [31:0] word;
		logic [30:0] len;
	} pcf_cmd_t;

	// Fold one byte into a reflected CRC-32, one bit per step.
	function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== sv/pcf_queue.sv =====
// Small register queue that decouples the classifying front from the emitting back.
`timescale 1ns / 1ps
module pcf_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pcf_pkg::pcf_cmd_t push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output pcf_pkg::pcf_cmd_t head_cmd
);
	import pcf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	pcf_cmd_t        entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign head_cmd = entry_q[rd_ptr_q];

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/pcf_front.sv =====
// Front end: accepts items, tracks the open chunk and classifies each item into a command.
`timescale 1ns / 1ps
module pcf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  pcf_pkg::pcf_in_t  item,
	output logic              push,
	output pcf_pkg::pcf_cmd_t push_cmd,
	input  logic              full
);
	import pcf_pkg::*;

	logic        chunk_open_q;
	logic [30:0] bytes_remaining_q;
	logic        accept;
	logic        last_byte;

	assign item_ready = !full;
	assign accept     = item_valid && !full;
	assign push       = accept;
	assign last_byte  = (bytes_remaining_q == 31'd1);

	// Classify the item against the chunk state.
	always_comb begin
		push_cmd.word = item.chunk_type;
		push_cmd.len  = item.payload_length;
		if (item.kind == KIND_HEADER) begin
			push_cmd.op = (item.payload_length == '0) ? OP_HDR_EMPTY : OP_HDR;
		end else begin
			push_cmd.word = {24'd0, item.data_byte};
			if (!chunk_open_q) begin
				push_cmd.op = OP_ERR;
			end else if (last_byte) begin
				push_cmd.op = OP_DATA_LAST;
			end else begin
				push_cmd.op = OP_DATA;
			end
		end
	end

	// Chunk state: a header with a nonzero length opens a chunk, the last payload byte closes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_open_q      <= 1'b0;
			bytes_remaining_q <= '0;
		end else if (accept) begin
			if (item.kind == KIND_HEADER) begin
				chunk_open_q      <= (item.payload_length != '0);
				bytes_remaining_q <= item.payload_length;
			end else if (chunk_open_q) begin
				bytes_remaining_q <= bytes_remaining_q - 31'd1;
				if (last_byte) begin
					chunk_open_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== sv/pcf_back.sv =====
// Back end: walks each command byte by byte, keeps the running CRC and drives the result register.
`timescale 1ns / 1ps
module pcf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  pcf_pkg::pcf_cmd_t head_cmd,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_ready,
	output pcf_pkg::pcf_out_t result
);
	import pcf_pkg::*;

	logic [3:0]  step_q;
	logic [31:0] crc_q;
	logic        result_valid_q;
	pcf_out_t    result_q;

	logic        load;
	logic        last_step;
	logic [3:0]  last_idx;
	logic [1:0]  crc_pos;
	logic [31:0] crc_out;
	logic [7:0]  crc_byte;
	logic [7:0]  type_byte;
	logic [31:0] len_word;
	logic [7:0]  len_byte;
	logic [31:0] crc_next;
	pcf_out_t    res_next;

	assign load         = !empty && (!result_valid_q || result_ready);
	assign last_step    = (step_q == last_idx);
	assign pop          = load && last_step;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Select the bytes that the current step may send.
	always_comb begin
		crc_out   = ~crc_q;
		crc_pos   = (head_cmd.op == OP_DATA_LAST) ? 2'(step_q - 4'd1) : 2'(step_q - 4'd8);
		crc_byte  = crc_out[8 * (3 - crc_pos) +: 8];
		type_byte = head_cmd.word[8 * (3 - step_q[1:0]) +: 8];
		len_word  = {1'b0, head_cmd.len};
		len_byte  = len_word[8 * (3 - step_q[1:0]) +: 8];
	end

	// Per-command sequence of result bytes and CRC updates.
	always_comb begin
		res_next = '0;
		crc_next = crc_q;
		last_idx = 4'd0;
		case (head_cmd.op)
			OP_HDR, OP_HDR_EMPTY: begin
				last_idx = (head_cmd.op == OP_HDR) ? 4'd7 : 4'd11;
				if (step_q < 4'd4) begin
					// Length bytes, most significant first; the CRC restarts here.
					res_next.out_byte = len_byte;
					crc_next = CRC_ONES;
				end else if (step_q < 4'd8) begin
					res_next.out_byte = type_byte;
					res_next.run_last = (head_cmd.op == OP_HDR) && (step_q == 4'd7);
					crc_next = crc_fold(crc_q, type_byte);
				end else begin
					res_next.out_byte   = crc_byte;
					res_next.run_last   = (step_q == 4'd11);
					res_next.chunk_done = (step_q == 4'd11);
					if (step_q == 4'd11) begin
						crc_next = CRC_ONES;
					end
				end
			end
			OP_DATA: begin
				res_next.out_byte = head_cmd.word[7:0];
				res_next.run_last = 1'b1;
				crc_next = crc_fold(crc_q, head_cmd.word[7:0]);
			end
			OP_DATA_LAST: begin
				last_idx = 4'd4;
				if (step_q == 4'd0) begin
					res_next.out_byte = head_cmd.word[7:0];
					crc_next = crc_fold(crc_q, head_cmd.word[7:0]);
				end else begin
					res_next.out_byte   = crc_byte;
					res_next.run_last   = (step_q == 4'd4);
					res_next.chunk_done = (step_q == 4'd4);
					if (step_q == 4'd4) begin
						crc_next = CRC_ONES;
					end
				end
			end
			OP_ERR: begin
				res_next.run_last      = 1'b1;
				res_next.framing_error = 1'b1;
			end
			default: begin
				res_next = '0;
			end
		endcase
	end

	// Step counter, CRC and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q         <= '0;
			crc_q          <= CRC_ONES;
			result_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q         <= last_step ? 4'd0 : step_q + 4'd1;
				crc_q          <= crc_next;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= res_next;
		end
	end

endmodule

// ===== sv/png_chunk_crc_framer_unit.sv =====
// Top level of the PNG chunk framer with CRC-32: front, command queue and back.
`timescale 1ns / 1ps
// An accepted item goes into a queue entry before the back registers its first result.
// Throughput: one result byte per cycle while a command waits and result_ready is high;
// a data byte gives one result byte (five when it closes the chunk), a header eight
// (twelve with zero length), all through the single output byte lane.
// The front accepts items while the queue has room, so it runs ahead of the back.
// Reset (arst_n low, asynchronous) closes any chunk, empties the queue and drops results.
module png_chunk_crc_framer_unit #(
	parameter int QUEUE_DEPTH = pcf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  pcf_pkg::pcf_in_t  item,
	output logic              result_valid,
	input  logic              result_ready,
	output pcf_pkg::pcf_out_t result
);
	import pcf_pkg::*;

	logic     push;
	logic     pop;
	logic     full;
	logic     empty;
	pcf_cmd_t push_cmd;
	pcf_cmd_t head_cmd;

	pcf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full)
	);

	pcf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head_cmd (head_cmd)
	);

	pcf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head_cmd     (head_cmd),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== sv/pcf_checker.sv =====
// Port-level checker for the PNG chunk framer, bound to the top level.
`timescale 1ns / 1ps
module pcf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input pcf_pkg::pcf_in_t  item,
	input logic              result_valid,
	input logic              result_ready,
	input pcf_pkg::pcf_out_t result
);
	import pcf_pkg::*;

	// A waiting input item holds.
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(item))
		else $error("input item changed while waiting");

	// A stalled result holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// The closing CRC byte is always the last result of its item.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.chunk_done |-> result.run_last)
		else $error("chunk_done without run_last");

	// An error result is a lone zero byte that closes nothing.
	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.framing_error |->
		result.run_last && !result.chunk_done && result.out_byte == 8'd0)
		else $error("malformed framing error result");

	// In the first cycle after reset no result is shown.
	a_quiet_start: assert property (@(posedge clk)
		!$past(arst_n) |-> !result_valid)
		else $error("result shown right after reset");

endmodule

bind png_chunk_crc_framer_unit pcf_checker u_pcf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

// ===== tb/sv/chunk_stream_checker.sv =====
// Checker that predicts the framed chunk byte stream and compares every result item.
`timescale 1ns / 1ps
module chunk_stream_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_ready,
	input  pcf_pkg::pcf_in_t  item,
	input  logic              result_valid,
	input  logic              result_ready,
	input  pcf_pkg::pcf_out_t result,
	output int                fail_count,
	output int                outstanding
);
	import pcf_pkg::*;

	// Predicted framer state.
	logic [31:0] crc_acc;
	logic [30:0] payload_left;
	logic        in_chunk;

	// Result bytes still owed by the block, oldest first.
	pcf_out_t    framed_bytes_q[$];

	// Reflected CRC-32 update, feeding each data bit in at the low end.
	function automatic logic [31:0] crc32_byte(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] r;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			r = {1'b0, r[31:1]} ^ (CRC_POLY & {32{r[0] ^ b[i]}});
		end
		return r;
	endfunction

	function automatic void push_byte(input logic [7:0] v, input logic last, input logic done,
			input logic err);
		pcf_out_t o;
		o.out_byte      = v;
		o.run_last      = last;
		o.chunk_done    = done;
		o.framing_error = err;
		framed_bytes_q = {framed_bytes_q, o};
	endfunction

	// Append the inverted CRC, most significant byte first, and close the chunk.
	function automatic void close_chunk();
		logic [31:0] crc_out;
		crc_out = crc_acc ^ CRC_ONES;
		for (int i = 3; i >= 0; i--) begin
			push_byte(crc_out[8*i +: 8], i == 0, i == 0, 1'b0);
		end
		crc_acc      = CRC_ONES;
		payload_left = '0;
		in_chunk     = 1'b0;
	endfunction

	// Work out every result byte that one accepted item causes.
	function automatic void predict_chunk_bytes(input pcf_in_t it);
		logic [31:0] len32;
		logic [31:0] crc;
		logic [7:0]  b;
		len32 = {1'b0, it.payload_length};
		if (it.kind == KIND_HEADER) begin
			for (int i = 3; i >= 0; i--) begin
				push_byte(len32[8*i +: 8], 1'b0, 1'b0, 1'b0);
			end
			crc = CRC_ONES;
			for (int i = 3; i >= 0; i--) begin
				b   = it.chunk_type[8*i +: 8];
				crc = crc32_byte(crc, b);
				push_byte(b, (len32 != 0) && (i == 0), 1'b0, 1'b0);
			end
			// A header drops any chunk still open and starts a new one.
			crc_acc      = crc;
			payload_left = it.payload_length;
			in_chunk     = 1'b1;
			if (len32 == 0) begin
				close_chunk();
			end
		end else if (!in_chunk) begin
			// Payload byte outside a chunk: a single error item, state untouched.
			push_byte(8'h00, 1'b1, 1'b0, 1'b1);
		end else begin
			crc_acc      = crc32_byte(crc_acc, it.data_byte);
			payload_left = payload_left - 31'd1;
			if (payload_left != 0) begin
				push_byte(it.data_byte, 1'b1, 1'b0, 1'b0);
			end else begin
				push_byte(it.data_byte, 1'b0, 1'b0, 1'b0);
				close_chunk();
			end
		end
	endfunction

	task automatic report(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		fail_count++;
	endtask

	// Compare one accepted result item with the oldest expected byte.
	task automatic check_result(input pcf_out_t got);
		pcf_out_t want;
		if (framed_bytes_q.size() == 0) begin
			report($sformatf("unexpected result byte %02h", got.out_byte));
		end else begin
			want = framed_bytes_q.pop_front();
			if (got.out_byte !== want.out_byte) begin
				report($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
			end
			if (got.run_last !== want.run_last) begin
				report($sformatf("run_last %b, expected %b", got.run_last, want.run_last));
			end
			if (got.chunk_done !== want.chunk_done) begin
				report($sformatf("chunk_done %b, expected %b", got.chunk_done,
					want.chunk_done));
			end
			if (got.framing_error !== want.framing_error) begin
				report($sformatf("framing_error %b, expected %b", got.framing_error,
					want.framing_error));
			end
		end
	endtask

	// Sample both channels at each edge; results are checked before new items are predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_acc      = CRC_ONES;
			payload_left = '0;
			in_chunk     = 1'b0;
			fail_count   = 0;
			framed_bytes_q.delete();
			outstanding <= 0;
		end else begin
			if (result_valid && result_ready) begin
				check_result(result);
			end
			if (item_valid && item_ready) begin
				predict_chunk_bytes(item);
			end
			outstanding <= framed_bytes_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_png_chunk_crc_framer_unit.sv =====
// Testbench top for the PNG chunk framer: clock, reset, item stimulus and the verdict.
`timescale 1ns / 1ps
module tb_png_chunk_crc_framer_unit;
	import pcf_pkg::*;

	localparam int ITEM_TARGET  = 430;
	localparam int HOLD_CYCLES  = 200;
	localparam int TAIL_CYCLES  = 16;
	localparam int RUN_LIMIT_NS = 2_000_000;

	// Stall patterns of the result side.
	typedef enum int {
		RDY_ALWAYS,
		RDY_HALF,
		RDY_SPARSE,
		RDY_MOSTLY
	} ready_mode_t;

	logic     clk          = 1'b0;
	logic     arst_n       = 1'b0;
	logic     item_valid   = 1'b0;
	logic     item_ready;
	pcf_in_t  item         = '0;
	logic     result_valid;
	logic     result_ready = 1'b0;
	pcf_out_t result;

	int fail_count;
	int outstanding;

	bit hold_request = 1'b0;
	bit no_gaps      = 1'b0;
	int burst_left   = 0;
	int items_sent   = 0;

	png_chunk_crc_framer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	chunk_stream_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("Simulation FAILED");
		$finish;
	end

	// Result side: random stall patterns, plus one long hold-off on request.
	initial begin : receiver
		ready_mode_t mode;
		int phase_left;
		mode = RDY_ALWAYS;
		phase_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				if (phase_left == 0) begin
					mode = ready_mode_t'($urandom_range(0, 3));
					phase_left = $urandom_range(16, 80);
				end
				phase_left--;
				case (mode)
					RDY_ALWAYS: result_ready <= 1'b1;
					RDY_HALF:   result_ready <= 1'($urandom_range(0, 1));
					RDY_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
					default:    result_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	function automatic pcf_in_t header_item(input logic [31:0] ctype, input logic [30:0] len);
		pcf_in_t it;
		it.kind           = KIND_HEADER;
		it.chunk_type     = ctype;
		it.payload_length = len;
		it.data_byte      = 8'($urandom);
		return it;
	endfunction

	function automatic pcf_in_t data_item(input logic [7:0] b);
		pcf_in_t it;
		it.kind           = KIND_DATA;
		it.chunk_type     = $urandom;
		it.payload_length = 31'($urandom);
		it.data_byte      = b;
		return it;
	endfunction

	// Offer one item and hold it until accepted; the sender works in bursts with gaps.
	task automatic offer_item(input pcf_in_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0 && !no_gaps) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	// Header followed by a number of random payload bytes.
	task automatic send_chunk(input logic [31:0] ctype, input logic [30:0] len, input int count);
		offer_item(header_item(ctype, len));
		for (int i = 0; i < count; i++) begin
			offer_item(data_item(8'($urandom)));
		end
	endtask

	// Stop offering items until every expected result has arrived.
	task automatic wait_results_drained();
		item_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [30:0] len;
		int pick;
		int r;
		bit hold_done;
		hold_done = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: stray byte, empty chunk, field extremes, a dropped chunk.
		offer_item(data_item(8'hff));
		offer_item(header_item("IEND", 31'd0));
		offer_item(header_item(32'hffff_ffff, 31'd1));
		offer_item(data_item(8'hff));
		offer_item(header_item(32'h0000_0000, 31'd2));
		offer_item(data_item(8'h00));
		offer_item(data_item(8'ha5));
		offer_item(header_item("tEXt", 31'h7fff_ffff));
		offer_item(data_item(8'h5a));
		offer_item(header_item("IDAT", 31'd3));
		offer_item(data_item(8'h01));
		offer_item(data_item(8'h80));
		offer_item(data_item(8'h7e));
		offer_item(data_item(8'h3c));
		offer_item(header_item("IHDR", 31'd0));
		wait_results_drained();

		// Random part: mostly complete chunks, with stray bytes and cut-off chunks mixed in.
		while (items_sent < ITEM_TARGET) begin
			if (!hold_done && items_sent >= 180) begin
				// Long hold-off on the result side while items keep coming.
				hold_done = 1'b1;
				wait_results_drained();
				hold_request = 1'b1;
				no_gaps = 1'b1;
				send_chunk($urandom, 31'd24, 24);
				no_gaps = 1'b0;
				wait_results_drained();
			end
			pick = $urandom_range(0, 15);
			if (pick == 0) begin
				offer_item(data_item(8'($urandom)));
			end else if (pick == 1) begin
				len = 31'($urandom);
				send_chunk($urandom, len, $urandom_range(0, 3));
			end else if (pick == 2) begin
				len = 31'($urandom_range(2, 10));
				send_chunk($urandom, len, $urandom_range(1, int'(len) - 1));
			end else begin
				r = $urandom_range(0, 15);
				if (r < 4) begin
					len = 31'd0;
				end else if (r == 15) begin
					len = 31'($urandom_range(13, 40));
				end else begin
					len = 31'($urandom_range(1, 12));
				end
				send_chunk($urandom, len, int'(len));
				if ($urandom_range(0, 19) == 0) begin
					wait_results_drained();
				end
			end
		end

		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
